@@ hdl/rqb_pkg.sv @@
package rqb_pkg;

    // Request queue sizing
    localparam int QUEUE_DEPTH     = 16;
    localparam int MAX_ITEM_LENGTH = 32;
    localparam int PTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W           = $clog2(QUEUE_DEPTH + 1);

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    // Backoff step table
    localparam int NUM_STEPS  = 5;
    localparam int STEP_IDX_W = 3;

    // Field widths
    localparam int ACT_W  = 3;
    localparam int TIME_W = 32;
    localparam int ADDR_W = 16;
    localparam int LEN_W  = 8;
    localparam int TAG_W  = 16;
    localparam int REF_W  = 16;
    localparam int ERR_W  = 8;
    localparam int KIND_W = 2;
    localparam int FC_W   = 8;
    localparam int CFG_IDX_W = 3;

    // Stream payload widths
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 80;

    // Input action codes
    localparam logic [ACT_W-1:0] ACT_READ          = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE         = 3'd1;
    localparam logic [ACT_W-1:0] ACT_HS_FAIL       = 3'd2;
    localparam logic [ACT_W-1:0] ACT_HS_OK         = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DONE_DATA     = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DONE_ERROR    = 3'd5;
    localparam logic [ACT_W-1:0] ACT_BACKOFF_CHECK = 3'd6;

    // Result kind codes
    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_FIRST      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SECOND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THIRD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_FOURTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_FINAL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_CODE    = 3'd6;

    // Configuration reset values
    localparam logic [TIME_W-1:0] STEP_RESET [NUM_STEPS] =
        '{32'd1000, 32'd2000, 32'd5000, 32'd10000, 32'd30000};
    localparam logic [FC_W-1:0]  PAUSE_THRESHOLD_RESET = 8'd5;
    localparam logic [ERR_W-1:0] TIMEOUT_CODE_RESET    = 8'd0;
    localparam logic [FC_W-1:0]  FC_MAX                = 8'hFF;

    // Classified command from the front part
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [TIME_W-1:0] now_ms;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [TAG_W-1:0]  request_tag;
        logic [REF_W-1:0]  data_ref;
        logic [ERR_W-1:0]  error_code;
        logic              req_fields_ok;
    } cmd_t;

    // Stored queue entry (the write handle is never delivered back)
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic              is_write;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              accepted;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic              is_write;
        logic [TAG_W-1:0]  tag;
        logic [REF_W-1:0]  data_ref;
        logic [ERR_W-1:0]  error;
        logic              backoff_active;
        logic              paused;
        logic [FC_W-1:0]   failure_count;
        logic              last;
    } result_t;

endpackage

@@ hdl/rqb_front.sv @@
module rqb_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rqb_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic [rqb_pkg::ACT_W-1:0]     s_axis_tuser,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output rqb_pkg::cmd_t                 cmd
);
    import rqb_pkg::*;

    localparam int CQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t                slots_reg [CMDQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] fill_reg, fill_next;
    cmd_t                in_cmd;
    logic                push, pop;

    // Unpack and classify: static request checks done here
    always_comb
    begin
        in_cmd.action      = s_axis_tuser;
        in_cmd.now_ms      = s_axis_tdata[31:0];
        in_cmd.address     = s_axis_tdata[47:32];
        in_cmd.length      = s_axis_tdata[55:48];
        in_cmd.request_tag = s_axis_tdata[71:56];
        in_cmd.data_ref    = s_axis_tdata[87:72];
        in_cmd.error_code  = s_axis_tdata[95:88];
        in_cmd.req_fields_ok = (in_cmd.length != '0)
            && (in_cmd.length <= LEN_W'(MAX_ITEM_LENGTH))
            && !((s_axis_tuser == ACT_WRITE) && (in_cmd.data_ref == '0));
    end

    assign s_axis_tready = (fill_reg != CQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid     = (fill_reg != '0);
    assign cmd           = slots_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = cmd_valid && cmd_ready;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Slot payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ hdl/rqb_back.sv @@
module rqb_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rqb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rqb_pkg::TIME_W-1:0]        cfg_data,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  rqb_pkg::cmd_t                     cmd,
    output logic                              res_valid,
    input  logic                              res_ready,
    output rqb_pkg::result_t                  res
);
    import rqb_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_EXEC     = 7'b0000010,
        S_STATUS   = 7'b0000100,
        S_FLUSH_RD = 7'b0001000,
        S_FLUSH_EM = 7'b0010000,
        S_DONE_RD  = 7'b0100000,
        S_DONE_EM  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cur_reg, cur_next;

    // Configuration
    logic [TIME_W-1:0] steps_reg [NUM_STEPS];
    logic [FC_W-1:0]   threshold_reg;
    logic [ERR_W-1:0]  timeout_reg;

    // Queue and backoff state
    entry_t            mem [QUEUE_DEPTH];
    entry_t            rd_data_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [FC_W-1:0]   fc_reg, fc_next;
    logic [TIME_W-1:0] retry_reg, retry_next;
    logic              paused_reg, paused_next;

    // Output register
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              out_free;
    logic              mem_we;
    entry_t            wr_entry;
    logic              req_ok;
    logic [FC_W-1:0]   fc_inc;
    logic [STEP_IDX_W-1:0] step_idx;
    logic [TIME_W-1:0] retry_sum;
    logic [TIME_W-1:0] retry_diff;
    logic              backoff;
    logic [PTR_W-1:0]  head_adv, tail_adv;
    result_t           base;

    assign cfg_ready = 1'b1;
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign out_free  = !out_valid_reg || res_ready;

    // Backoff flag at this item's time
    assign retry_diff = cur_reg.now_ms - retry_reg;
    assign backoff    = (retry_reg != '0) && retry_diff[TIME_W-1];

    // Failure bookkeeping
    assign fc_inc    = (fc_reg != FC_MAX) ? fc_reg + 1'b1 : fc_reg;
    assign step_idx  = (fc_inc >= FC_W'(NUM_STEPS)) ? STEP_IDX_W'(NUM_STEPS - 1)
                                                   : STEP_IDX_W'(fc_inc - 1'b1);
    assign retry_sum = cur_reg.now_ms + steps_reg[step_idx];

    assign head_adv = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_adv = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    assign req_ok = cur_reg.req_fields_ok && !paused_reg
                    && (count_reg != CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        wr_entry.address  = cur_reg.address;
        wr_entry.length   = cur_reg.length;
        wr_entry.is_write = (cur_reg.action == ACT_WRITE);
        wr_entry.tag      = cur_reg.request_tag;
    end

    // Common result fields: status flags reflect the updated state
    always_comb
    begin
        base                = '0;
        base.kind           = KIND_STATUS;
        base.backoff_active = backoff;
        base.paused         = paused_reg;
        base.failure_count  = fc_reg;
        base.last           = 1'b1;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        fc_next        = fc_reg;
        retry_next     = retry_reg;
        paused_next    = paused_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res_ready;
        mem_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next   = cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (cur_reg.action)
                    ACT_READ, ACT_WRITE:
                    begin
                        if (out_free)
                        begin
                            if (req_ok)
                            begin
                                mem_we     = 1'b1;
                                tail_next  = tail_adv;
                                count_next = count_reg + 1'b1;
                            end
                            out_next          = base;
                            out_next.kind     = KIND_ACK;
                            out_next.accepted = req_ok;
                            out_valid_next    = 1'b1;
                            state_next        = S_IDLE;
                        end
                    end
                    ACT_HS_FAIL:
                    begin
                        fc_next    = fc_inc;
                        retry_next = (retry_sum == '0) ? TIME_W'(1) : retry_sum;
                        state_next = S_STATUS;
                        if (fc_inc >= threshold_reg)
                        begin
                            paused_next = 1'b1;
                            if (!paused_reg && (count_reg != '0))
                            begin
                                state_next = S_FLUSH_RD;
                            end
                        end
                    end
                    ACT_HS_OK:
                    begin
                        fc_next     = '0;
                        retry_next  = '0;
                        paused_next = 1'b0;
                        state_next  = S_STATUS;
                    end
                    ACT_DONE_DATA, ACT_DONE_ERROR:
                    begin
                        state_next = (count_reg != '0) ? S_DONE_RD : S_STATUS;
                    end
                    default:
                    begin
                        state_next = S_STATUS;
                    end
                endcase
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    out_next       = base;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_FLUSH_RD:
            begin
                // read data for the new head lands in rd_data_reg
                state_next = S_FLUSH_EM;
            end
            S_FLUSH_EM:
            begin
                if (out_free)
                begin
                    out_next          = base;
                    out_next.kind     = KIND_ERROR;
                    out_next.address  = rd_data_reg.address;
                    out_next.length   = rd_data_reg.length;
                    out_next.is_write = rd_data_reg.is_write;
                    out_next.tag      = rd_data_reg.tag;
                    out_next.error    = timeout_reg;
                    out_next.last     = 1'b0;
                    out_valid_next    = 1'b1;
                    head_next         = head_adv;
                    count_next        = count_reg - 1'b1;
                    state_next = (count_reg == CNT_W'(1)) ? S_STATUS : S_FLUSH_RD;
                end
            end
            S_DONE_RD:
            begin
                state_next = S_DONE_EM;
            end
            S_DONE_EM:
            begin
                if (out_free)
                begin
                    out_next          = base;
                    out_next.address  = rd_data_reg.address;
                    out_next.is_write = rd_data_reg.is_write;
                    out_next.tag      = rd_data_reg.tag;
                    if (cur_reg.action == ACT_DONE_DATA)
                    begin
                        out_next.kind     = KIND_DATA;
                        out_next.length   = cur_reg.length;
                        out_next.data_ref = cur_reg.data_ref;
                    end
                    else
                    begin
                        out_next.kind   = KIND_ERROR;
                        out_next.length = rd_data_reg.length;
                        out_next.error  = cur_reg.error_code;
                    end
                    out_valid_next = 1'b1;
                    head_next      = head_adv;
                    count_next     = count_reg - 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            fc_reg        <= '0;
            retry_reg     <= '0;
            paused_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            fc_reg        <= fc_next;
            retry_reg     <= retry_next;
            paused_reg    <= paused_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg     <= STEP_RESET;
            threshold_reg <= PAUSE_THRESHOLD_RESET;
            timeout_reg   <= TIMEOUT_CODE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_STEP_FIRST, CFG_STEP_SECOND, CFG_STEP_THIRD,
                CFG_STEP_FOURTH, CFG_STEP_FINAL:
                begin
                    steps_reg[cfg_index] <= cfg_data;
                end
                CFG_PAUSE_THRESHOLD:
                begin
                    threshold_reg <= cfg_data[FC_W-1:0];
                end
                CFG_TIMEOUT_CODE:
                begin
                    timeout_reg <= cfg_data[ERR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    // Entry memory: write at tail, registered read at head
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= wr_entry;
        end
        rd_data_reg <= mem[head_reg];
    end

endmodule

@@ hdl/request_queue_with_retry_backoff.sv @@
// Link request queue with handshake retry backoff.
//
// Items enter on the s_axis stream (tuser selects the action) and results leave
// on the m_axis stream; tlast marks the final result of an input item. Requests
// get one ack, completions one delivery of the front queue entry or a status
// result if the queue is empty, handshake and backoff events one status result.
// A handshake failure that first pauses polling emits one timeout error delivery
// per queued entry before its status. Configuration writes use the cfg channel;
// cfg_ready is always high, so write only while no item is in flight.
//
// An input item waits in the command queue and is then run by the back engine.
// A request ack goes straight to the output register, a status result first
// passes the status state, and a completion the read state for the registered
// read of the entry memory at the head; a pause flush adds a read and an emit
// state per queued entry. The engine works on one item at a time; a two-entry
// command queue takes new items while the engine works or its output is held.
// Reset empties the queue, clears the failure count, retry time and pause, and
// loads the default step table, threshold and timeout code. When the receiver
// holds m_axis_tready low the engine stops at its next result and the command
// queue fills, then s_axis_tready drops.
module request_queue_with_retry_backoff (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // now_ms[31:0], address[47:32], length[55:48], request_tag[71:56],
    // data_ref[87:72], error_code[95:88]
    input  logic [rqb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action[2:0]
    input  logic [rqb_pkg::ACT_W-1:0]      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // accepted[0], out_address[16:1], out_length[24:17], out_is_write[25],
    // out_tag[41:26], out_data_ref[57:42], out_error[65:58], backoff_active[66],
    // paused[67], failure_count_out[75:68], zero fill[79:76]
    output logic [rqb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // kind[1:0]
    output logic [rqb_pkg::KIND_W-1:0]     m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rqb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rqb_pkg::TIME_W-1:0]     cfg_data
);
    import rqb_pkg::*;

    logic    cmd_valid;
    logic    cmd_ready;
    cmd_t    cmd;
    result_t res;

    rqb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    rqb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Result packing
    assign m_axis_tdata = {4'b0000, res.failure_count, res.paused, res.backoff_active,
                           res.error, res.data_ref, res.tag, res.is_write,
                           res.length, res.address, res.accepted};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

@@ tb/sv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rqb_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 16;

    // Clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    // DUT stimulus, all known from time zero
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [ACT_W-1:0]      s_tuser = '0;
    logic                  m_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [TIME_W-1:0]     cfg_data = '0;

    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_ready;

    request_queue_with_retry_backoff dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        // now_ms[31:0], address[47:32], length[55:48], request_tag[71:56],
        // data_ref[87:72], error_code[95:88]
        .s_axis_tdata  (s_tdata),
        // action[2:0]
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        // accepted[0], out_address[16:1], out_length[24:17], out_is_write[25],
        // out_tag[41:26], out_data_ref[57:42], out_error[65:58],
        // backoff_active[66], paused[67], failure_count_out[75:68]
        .m_axis_tdata  (m_axis_tdata),
        // kind[1:0]
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Shared testbench state
    int      src_idle_pct = 0;
    int      sink_stall_pct = 0;
    int      mismatches = 0;
    int      cycle_count = 0;
    logic    hold_on = 1'b0;
    event    hold_ev;
    logic [TIME_W-1:0] clock_ms = '0;

    // Predicted block state
    logic [ADDR_W-1:0] q_addr [QUEUE_DEPTH];
    logic [LEN_W-1:0]  q_len  [QUEUE_DEPTH];
    logic              q_wr   [QUEUE_DEPTH];
    logic [TAG_W-1:0]  q_tag  [QUEUE_DEPTH];
    int                q_head = 0;
    int                q_count = 0;
    logic [FC_W-1:0]   fail_count = '0;
    logic [TIME_W-1:0] retry_ms = '0;
    logic              paused_q = 1'b0;
    logic [TIME_W-1:0] step_ms [NUM_STEPS] = STEP_RESET;
    logic [FC_W-1:0]   pause_thr = PAUSE_THRESHOLD_RESET;
    logic [ERR_W-1:0]  flush_code = TIMEOUT_CODE_RESET;

    // Results still owed by the block, oldest first
    result_t link_results_due [$];

    // One result built from the current predicted state
    function automatic result_t make_result(logic [KIND_W-1:0] kind, logic acc,
                                            logic [ADDR_W-1:0] addr,
                                            logic [LEN_W-1:0] len, logic wr,
                                            logic [TAG_W-1:0] tag,
                                            logic [REF_W-1:0] dref,
                                            logic [ERR_W-1:0] err,
                                            logic [TIME_W-1:0] now, logic last);
        result_t r;
        logic [TIME_W-1:0] diff;
        diff = now - retry_ms;
        r.kind = kind;
        r.accepted = acc;
        r.address = addr;
        r.length = len;
        r.is_write = wr;
        r.tag = tag;
        r.data_ref = dref;
        r.error = err;
        r.backoff_active = (retry_ms != '0) && diff[TIME_W-1];
        r.paused = paused_q;
        r.failure_count = fail_count;
        r.last = last;
        return r;
    endfunction

    // Update predicted state for one accepted item and queue its results
    function automatic void predict_link_results(logic [ACT_W-1:0] act,
                                                 logic [IN_DATA_W-1:0] d);
        logic [TIME_W-1:0] now;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [TAG_W-1:0]  tag;
        logic [REF_W-1:0]  dref;
        logic [ERR_W-1:0]  err;
        logic              ok;
        logic              prior_pause;
        int                slot;
        int                idx;
        now  = d[31:0];
        addr = d[47:32];
        len  = d[55:48];
        tag  = d[71:56];
        dref = d[87:72];
        err  = d[95:88];
        case (act)
            ACT_READ, ACT_WRITE:
            begin
                ok = !paused_q && len != 0 && len <= MAX_ITEM_LENGTH
                     && !(act == ACT_WRITE && dref == '0) && q_count < QUEUE_DEPTH;
                if (ok)
                begin
                    slot = (q_head + q_count) % QUEUE_DEPTH;
                    q_addr[slot] = addr;
                    q_len[slot] = len;
                    q_wr[slot] = (act == ACT_WRITE);
                    q_tag[slot] = tag;
                    q_count++;
                end
                link_results_due.push_back(make_result(KIND_ACK, ok, '0, '0, 1'b0, '0,
                                                       '0, '0, now, 1'b1));
            end
            ACT_HS_FAIL:
            begin
                if (fail_count < FC_MAX)
                    fail_count = fail_count + 1'b1;
                idx = int'(fail_count) - 1;
                if (idx >= NUM_STEPS)
                    idx = NUM_STEPS - 1;
                retry_ms = now + step_ms[idx];
                if (retry_ms == '0)
                    retry_ms = 32'd1;
                if (fail_count >= pause_thr)
                begin
                    prior_pause = paused_q;
                    paused_q = 1'b1;
                    // first pause drains the whole queue with the timeout code
                    if (!prior_pause)
                    begin
                        while (q_count > 0)
                        begin
                            slot = q_head;
                            q_head = (q_head + 1) % QUEUE_DEPTH;
                            q_count--;
                            link_results_due.push_back(make_result(KIND_ERROR, 1'b0,
                                q_addr[slot], q_len[slot], q_wr[slot], q_tag[slot],
                                '0, flush_code, now, 1'b0));
                        end
                    end
                end
                link_results_due.push_back(make_result(KIND_STATUS, 1'b0, '0, '0, 1'b0,
                                                       '0, '0, '0, now, 1'b1));
            end
            ACT_DONE_DATA, ACT_DONE_ERROR:
            begin
                if (q_count > 0)
                begin
                    slot = q_head;
                    q_head = (q_head + 1) % QUEUE_DEPTH;
                    q_count--;
                    if (act == ACT_DONE_DATA)
                        link_results_due.push_back(make_result(KIND_DATA, 1'b0,
                            q_addr[slot], len, q_wr[slot], q_tag[slot], dref, '0,
                            now, 1'b1));
                    else
                        link_results_due.push_back(make_result(KIND_ERROR, 1'b0,
                            q_addr[slot], q_len[slot], q_wr[slot], q_tag[slot], '0,
                            err, now, 1'b1));
                end
                else
                    link_results_due.push_back(make_result(KIND_STATUS, 1'b0, '0, '0,
                                                           1'b0, '0, '0, '0, now, 1'b1));
            end
            default:
            begin
                // handshake ok clears the backoff; a check only reports
                if (act == ACT_HS_OK)
                begin
                    fail_count = '0;
                    retry_ms = '0;
                    paused_q = 1'b0;
                end
                link_results_due.push_back(make_result(KIND_STATUS, 1'b0, '0, '0, 1'b0,
                                                       '0, '0, '0, now, 1'b1));
            end
        endcase
    endfunction

    // Mismatch reporting
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // Result checker
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_ready)
        begin
            got.kind = m_axis_tuser;
            got.accepted = m_axis_tdata[0];
            got.address = m_axis_tdata[16:1];
            got.length = m_axis_tdata[24:17];
            got.is_write = m_axis_tdata[25];
            got.tag = m_axis_tdata[41:26];
            got.data_ref = m_axis_tdata[57:42];
            got.error = m_axis_tdata[65:58];
            got.backoff_active = m_axis_tdata[66];
            got.paused = m_axis_tdata[67];
            got.failure_count = m_axis_tdata[75:68];
            got.last = m_axis_tlast;
            if (link_results_due.size() == 0)
                report_mismatch($sformatf("result kind %0d with nothing outstanding",
                                          got.kind));
            else
            begin
                want = link_results_due.pop_front();
                compare_field("kind", 32'(got.kind), 32'(want.kind));
                compare_field("accepted", 32'(got.accepted), 32'(want.accepted));
                compare_field("address", 32'(got.address), 32'(want.address));
                compare_field("length", 32'(got.length), 32'(want.length));
                compare_field("is_write", 32'(got.is_write), 32'(want.is_write));
                compare_field("tag", 32'(got.tag), 32'(want.tag));
                compare_field("data_ref", 32'(got.data_ref), 32'(want.data_ref));
                compare_field("error", 32'(got.error), 32'(want.error));
                compare_field("backoff_active", 32'(got.backoff_active),
                              32'(want.backoff_active));
                compare_field("paused", 32'(got.paused), 32'(want.paused));
                compare_field("failure_count", 32'(got.failure_count),
                              32'(want.failure_count));
                compare_field("last", 32'(got.last), 32'(want.last));
            end
        end
    end

    // Receiver ready, random stalls unless a long hold is running
    always @(posedge clk)
    begin
        if (hold_on)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Long receiver hold, counted here
    initial
    begin
        forever
        begin
            @(hold_ev);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one item, wait for the transfer, then predict it
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [TIME_W-1:0] now,
                             input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len,
                             input logic [TAG_W-1:0] tag, input logic [REF_W-1:0] dref,
                             input logic [ERR_W-1:0] err);
        logic [IN_DATA_W-1:0] d;
        bit idled;
        d = {err, dref, tag, len, addr, now};
        idled = 0;
        while ($urandom_range(99) < src_idle_pct)
        begin
            if (!idled)
                s_valid <= 1'b0;
            idled = 1;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_tdata <= d;
        s_tuser <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_link_results(act, d);
    endtask

    // Register write over the cfg channel, cfg_valid dropped after each transfer
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [TIME_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PAUSE_THRESHOLD: pause_thr = value[FC_W-1:0];
            CFG_TIMEOUT_CODE:    flush_code = value[ERR_W-1:0];
            default:             step_ms[idx] = value;
        endcase
        @(posedge clk);
    endtask

    // Stop offering and let every owed result come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (link_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Requests, completions and wrap of the retry time with default registers
    task automatic test_request_paths();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        send_item(ACT_READ, 32'd0, 16'h0000, 8'd1, 16'h0000, 16'h0000, 8'h00);
        send_item(ACT_WRITE, 32'd100, 16'hFFFF, 8'd32, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_item(ACT_READ, 32'd200, 16'h1234, 8'd0, 16'h0001, 16'h0000, 8'h00);
        send_item(ACT_READ, 32'd210, 16'h1234, 8'd33, 16'h0002, 16'h0000, 8'h00);
        send_item(ACT_WRITE, 32'd220, 16'h4321, 8'd255, 16'h0003, 16'h0005, 8'h00);
        send_item(ACT_WRITE, 32'd230, 16'h5555, 8'd8, 16'h0004, 16'h0000, 8'h00);
        send_item(ACT_DONE_DATA, 32'd300, 16'h0000, 8'd255, 16'h0000, 16'hFFFF, 8'h00);
        send_item(ACT_DONE_ERROR, 32'd310, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'hFF);
        // completions with nothing queued
        send_item(ACT_DONE_DATA, 32'd320, 16'hAAAA, 8'd4, 16'h1111, 16'h2222, 8'h33);
        send_item(ACT_DONE_ERROR, 32'd330, 16'hAAAA, 8'd4, 16'h1111, 16'h2222, 8'h33);
        send_item(ACT_BACKOFF_CHECK, 32'd340, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'h00);
        // now + first step wraps to zero, forced to 1
        send_item(ACT_HS_FAIL, 32'hFFFF_FC18, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'h00);
        send_item(ACT_BACKOFF_CHECK, 32'd0, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'h00);
        send_item(ACT_BACKOFF_CHECK, 32'd1, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'h00);
        send_item(ACT_HS_OK, 32'd2, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'h00);
        wait_idle();
    endtask

    // Extreme register values, pause on first failure, no second flush
    task automatic test_register_extremes();
        write_register(CFG_STEP_FIRST, 32'h0000_0000);
        write_register(CFG_STEP_SECOND, 32'h0000_0001);
        write_register(CFG_STEP_THIRD, 32'h7FFF_FFFF);
        write_register(CFG_STEP_FOURTH, 32'h8000_0000);
        write_register(CFG_STEP_FINAL, 32'hFFFF_FFFF);
        write_register(CFG_PAUSE_THRESHOLD, 32'd1);
        write_register(CFG_TIMEOUT_CODE, 32'hFF);
        send_item(ACT_READ, 32'd0, 16'h0F0F, 8'd4, 16'hBEEF, 16'h0000, 8'h00);
        send_item(ACT_WRITE, 32'd0, 16'hF0F0, 8'd32, 16'hCAFE, 16'h0001, 8'h00);
        // zero step at time zero sums to a zero retry time, forced to 1
        send_item(ACT_HS_FAIL, 32'd0, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'h00);
        send_item(ACT_READ, 32'd5, 16'h0101, 8'd2, 16'h0102, 16'h0000, 8'h00);
        send_item(ACT_HS_FAIL, 32'd10, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'h00);
        send_item(ACT_HS_FAIL, 32'd20, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'h00);
        send_item(ACT_HS_FAIL, 32'd30, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'h00);
        send_item(ACT_HS_FAIL, 32'd40, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'h00);
        send_item(ACT_HS_FAIL, 32'hFFFF_FFFF, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'h00);
        send_item(ACT_BACKOFF_CHECK, 32'h8000_0000, 16'h0000, 8'd0, 16'h0000, 16'h0000,
                  8'h00);
        send_item(ACT_HS_OK, 32'd50, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'h00);
        wait_idle();
    endtask

    // Receiver holds off while requests keep coming, then a full-queue flush
    task automatic test_full_queue_pressure();
        int i;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        for (i = 0; i < NUM_STEPS; i++)
            write_register(CFG_STEP_FIRST + CFG_IDX_W'(i), STEP_RESET[i]);
        write_register(CFG_PAUSE_THRESHOLD, TIME_W'(PAUSE_THRESHOLD_RESET));
        write_register(CFG_TIMEOUT_CODE, 32'h3C);
        send_item(ACT_HS_OK, 32'd1000, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'h00);
        -> hold_ev;
        for (i = 0; i < QUEUE_DEPTH + 2; i++)
            send_item((i % 2) ? ACT_WRITE : ACT_READ, 32'd1000 + i,
                      ADDR_W'($urandom()), LEN_W'($urandom_range(1, MAX_ITEM_LENGTH)),
                      TAG_W'($urandom()), REF_W'($urandom_range(1, 65535)),
                      ERR_W'($urandom()));
        for (i = 0; i < 5; i++)
            send_item(ACT_HS_FAIL, 32'd2000 + 100 * i, 16'h0000, 8'd0, 16'h0000,
                      16'h0000, 8'h00);
        send_item(ACT_HS_OK, 32'd3000, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'h00);
        wait_idle();
    endtask

    // Threshold at its top: pause on the 255th failure, count saturates
    task automatic test_failure_saturation();
        int i;
        src_idle_pct = 0;
        sink_stall_pct = 29;
        write_register(CFG_PAUSE_THRESHOLD, 32'd255);
        write_register(CFG_TIMEOUT_CODE, 32'h5A);
        send_item(ACT_READ, 32'd0, 16'h00FF, 8'd16, 16'h0A0A, 16'h0000, 8'h00);
        send_item(ACT_WRITE, 32'd0, 16'hFF00, 8'd1, 16'h0B0B, 16'h7777, 8'h00);
        for (i = 0; i < 256; i++)
            send_item(ACT_HS_FAIL, 32'd37 * i, 16'h0000, 8'd0, 16'h0000, 16'h0000,
                      8'h00);
        send_item(ACT_HS_OK, 32'd20000, 16'h0000, 8'd0, 16'h0000, 16'h0000, 8'h00);
        wait_idle();
    endtask

    // Random traffic, mostly well-formed request/complete cycles
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int n_items);
        logic [ACT_W-1:0]  act;
        logic [TIME_W-1:0] now;
        logic [LEN_W-1:0]  len;
        logic [REF_W-1:0]  dref;
        int pick;
        int i;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        // fresh register setting for this phase
        for (i = 0; i < NUM_STEPS; i++)
            write_register(CFG_STEP_FIRST + CFG_IDX_W'(i),
                           ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 5000));
        pick = $urandom_range(9);
        write_register(CFG_PAUSE_THRESHOLD,
                       (pick == 0) ? 32'd255 : (pick == 1) ? 32'd1 : $urandom_range(2, 6));
        write_register(CFG_TIMEOUT_CODE, $urandom_range(0, 255));
        for (i = 0; i < n_items; i++)
        begin
            if ($urandom_range(19) == 0)
                clock_ms = $urandom();
            else
                clock_ms = clock_ms + $urandom_range(0, 4000);
            now = clock_ms;
            pick = $urandom_range(99);
            if (pick < 42)
                act = ($urandom_range(2) == 0) ? ACT_WRITE : ACT_READ;
            else if (pick < 72)
                act = ($urandom_range(1) == 0) ? ACT_DONE_DATA : ACT_DONE_ERROR;
            else if (pick < 82)
                act = ACT_HS_FAIL;
            else if (pick < 92)
                act = ACT_HS_OK;
            else
            begin
                act = ACT_BACKOFF_CHECK;
                // probe right around the retry boundary
                if ($urandom_range(1) == 0)
                    now = retry_ms + $urandom_range(0, 2) - 1;
            end
            if (act == ACT_READ || act == ACT_WRITE)
                len = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(0, 255))
                                               : LEN_W'($urandom_range(1, MAX_ITEM_LENGTH));
            else
                len = LEN_W'($urandom_range(0, 255));
            if (act == ACT_WRITE)
                dref = ($urandom_range(11) == 0) ? 16'h0000
                                                 : REF_W'($urandom_range(1, 65535));
            else
                dref = REF_W'($urandom_range(0, 65535));
            send_item(act, now, ADDR_W'($urandom()), len, TAG_W'($urandom()), dref,
                      ERR_W'($urandom()));
        end
        wait_idle();
    endtask

    // Sequence of tests
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_request_paths();
        test_register_extremes();
        test_full_queue_pressure();
        test_failure_saturation();
        test_random_traffic(0, 0, 10);
        test_random_traffic(77, 0, 10);
        test_random_traffic(0, 77, 10);
        test_random_traffic(29, 29, 10);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
